[src/sorted_range_count_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef SORTED_RANGE_COUNT_TOP_DEFINES_SVH
`define SORTED_RANGE_COUNT_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SRC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define SRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[src/src_pkg.sv]
// Package: sizes, types and state codes of the sorted range counter.
package src_pkg;
	localparam int Capacity = 1024;
	localparam int AddrW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);
	localparam int OutW = 11;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_QUERY = 2'd1
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WAIT,
		ST_SHIFT,
		ST_DONE
	} state_t;
endpackage

[src/sorted_range_count_top.sv]
// Top level: sorted store with insert-by-shift and binary-search range count.
//
// Usage: drive start with cmd and payload while busy is low; the word is taken
// at that edge and busy rises the cycle after. cmd 0 loads position into the
// ascending store (no result); cmd 1 counts stored positions in
// [range_low, range_high] and returns match_count and dropped_flag for one
// cycle, marked by done. The receiver cannot stall; done is a pulse.
// Query: two binary searches; each step issues a read of the memory (separate
// read and write ports) in ST_SEARCH and compares the registered read data in
// ST_WAIT. A query with range_low above range_high skips the searches and
// returns zero. done rises in the same cycle that busy falls.
// Load: one binary search, then a shift of every entry from the insert point
// up, each entry moved one place up by a read followed by a write.
// Loads into a full store are dropped and set the sticky dropped flag.
// Reset empties the store by clearing the fill count; the memory itself is not
// cleared, since only entries below the count are ever read.
module sorted_range_count_top
	import src_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic signed [31:0]   position,
	input  logic signed [31:0]   range_low,
	input  logic signed [31:0]   range_high,
	output logic                 done,
	output logic [OutW-1:0]      match_count,
	output logic                 dropped_flag
);
	// store memory
	logic signed [31:0] mem [Capacity];
	logic signed [31:0] rd_data_q;
	logic [AddrW-1:0]   rd_addr;
	logic               wr_en;
	logic [AddrW-1:0]   wr_addr;
	logic signed [31:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	state_t state_q, state_d;
	logic [CntW-1:0] count_q, lo_q, hi_q, idx_q, first_q;
	logic [CntW-1:0] count_d, lo_d, hi_d, idx_d, first_d;
	logic            is_query_q, pass_q, overflow_q, done_q;
	logic            is_query_d, pass_d, overflow_d, done_d;
	logic signed [31:0] key_q, key_hi_q, key_d;
	logic [OutW-1:0] res_q, res_d;
	logic [CntW-1:0] mid;
	logic            go_left;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign match_count = res_q;
	assign dropped_flag = overflow_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			overflow_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			overflow_q <= overflow_d;
			done_q <= done_d;
		end
	end

	// datapath registers; upper key of a query is kept for the second pass
	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
		idx_q <= idx_d;
		first_q <= first_d;
		is_query_q <= is_query_d;
		pass_q <= pass_d;
		key_q <= key_d;
		res_q <= res_d;
		if (state_q == ST_IDLE && start) begin
			key_hi_q <= range_high;
		end
	end

	// search step: first pass of a query is lower bound of low, else upper bound
	always_comb begin
		if (is_query_q && !pass_q) begin
			go_left = (rd_data_q >= key_q);
		end else begin
			go_left = (rd_data_q > key_q);
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		overflow_d = overflow_q;
		done_d = 1'b0;
		lo_d = lo_q;
		hi_d = hi_q;
		idx_d = idx_q;
		first_d = first_q;
		is_query_d = is_query_q;
		pass_d = pass_q;
		key_d = key_q;
		res_d = res_q;
		rd_addr = mid[AddrW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[AddrW-1:0];
		wr_data = key_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					lo_d = '0;
					hi_d = count_q;
					pass_d = 1'b0;
					is_query_d = (cmd == CMD_QUERY[0]);
					if (cmd == CMD_QUERY[0]) begin
						key_d = range_low;
						if (range_low > range_high) begin
							res_d = '0;
							state_d = ST_DONE;
						end else begin
							state_d = ST_SEARCH;
						end
					end else begin
						key_d = position;
						if (count_q >= CntW'(Capacity)) begin
							overflow_d = 1'b1;
							state_d = ST_DONE;
						end else begin
							state_d = ST_SEARCH;
						end
					end
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					state_d = ST_WAIT;
				end else if (is_query_q && !pass_q) begin
					first_d = lo_q;
					pass_d = 1'b1;
					key_d = key_hi_q;
					lo_d = '0;
					hi_d = count_q;
				end else if (is_query_q) begin
					res_d = OutW'(lo_q - first_q);
					state_d = ST_DONE;
				end else begin
					// insert point found: shift entries from the top down
					first_d = lo_q;
					idx_d = count_q;
					state_d = ST_SHIFT;
				end
			end
			ST_WAIT: begin
				if (go_left) begin
					hi_d = mid;
				end else begin
					lo_d = mid + 1'b1;
				end
				state_d = ST_SEARCH;
			end
			ST_SHIFT: begin
				// read idx-1 is issued on the cycle with pass set low
				rd_addr = AddrW'(idx_q - 1'b1);
				if (idx_q == first_q) begin
					wr_en = 1'b1;
					wr_data = key_q;
					count_d = count_q + 1'b1;
					state_d = ST_DONE;
				end else if (!pass_q) begin
					pass_d = 1'b1;
				end else begin
					wr_en = 1'b1;
					wr_data = rd_data_q;
					idx_d = idx_q - 1'b1;
					pass_d = 1'b0;
				end
			end
			ST_DONE: begin
				done_d = is_query_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_SEARCH && !is_query_q && lo_q >= hi_q) begin
			pass_d = 1'b0;
		end
	end
endmodule

[src/src_checker.sv]
// Port checker for the sorted range counter, bound to the top level.
`include "sorted_range_count_top_defines.svh"
module src_checker
	import src_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input logic [OutW-1:0] match_count,
	input logic            dropped_flag
);
	// accepted word makes busy high next cycle
	`SRC_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy missing after start")
	// result strobe is a single pulse
	`SRC_ASSERT_NEXT(a_done_pulse, done, !done, "done longer than one cycle")
	// dropped flag is sticky
	`SRC_ASSERT_NEXT(a_drop_sticky, dropped_flag, dropped_flag, "dropped flag cleared")
	// count never exceeds capacity
	`SRC_ASSERT_IMP(a_count_range, done, match_count <= OutW'(Capacity), "count too large")
endmodule

bind sorted_range_count_top src_checker u_src_checker (.*);

[tb/tb_top.sv]
// Testbench for sorted_range_count_top: loads and range queries checked against a sorted-store predictor.
`timescale 1ns / 100ps

module tb_top;
	import src_pkg::*;

	localparam int IdleLimit = 20000;
	localparam int DrainCycles = 60;

	typedef struct {
		cmd_code_t       op;
		logic signed [31:0] pos;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		bit              drain;
	} word_t;

	typedef struct {
		logic [OutW-1:0] cnt;
		logic            flag;
	} answer_t;

	logic clk, arst_n, start, busy, cmd, done, dropped_flag;
	logic signed [31:0] position, range_low, range_high;
	logic [OutW-1:0] match_count;

	sorted_range_count_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.position(position), .range_low(range_low), .range_high(range_high),
		.done(done), .match_count(match_count), .dropped_flag(dropped_flag)
	);

	word_t   pending_words[$];
	answer_t expected_answers[$];
	logic signed [31:0] loaded_vals[$];

	// predictor state: ascending store, fill and sticky overflow
	logic signed [31:0] store_vals [Capacity];
	int unsigned        store_fill;
	bit                 store_overflow;

	int  err_cnt;
	int  idle_cycles;
	int  gap_left;
	bit  took;
	bit  stim_done;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
		err_cnt++;
	endtask

	// insert after any equal entries, as upper bound does
	function automatic void store_insert(input logic signed [31:0] v);
		int unsigned at;
		if (store_fill >= Capacity) begin
			store_overflow = 1'b1;
			return;
		end
		at = store_fill;
		while (at > 0 && store_vals[at-1] > v) begin
			store_vals[at] = store_vals[at-1];
			at--;
		end
		store_vals[at] = v;
		store_fill++;
	endfunction

	function automatic answer_t count_in_range(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		answer_t a;
		int unsigned n;
		n = 0;
		if (lo <= hi)
			for (int unsigned i = 0; i < store_fill; i++)
				if (store_vals[i] >= lo && store_vals[i] <= hi) n++;
		a.cnt = n[OutW-1:0];
		a.flag = store_overflow;
		return a;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_load(input logic signed [31:0] v);
		word_t w;
		w.op = CMD_LOAD; w.pos = v; w.lo = $urandom; w.hi = $urandom; w.drain = 1'b0;
		pending_words.push_back(w);
		loaded_vals.push_back(v);
	endtask

	task automatic add_query(input logic signed [31:0] lo, input logic signed [31:0] hi,
			input bit drain);
		word_t w;
		w.op = CMD_QUERY; w.pos = $urandom; w.lo = lo; w.hi = hi; w.drain = drain;
		pending_words.push_back(w);
	endtask

	function automatic logic signed [31:0] some_loaded();
		if (loaded_vals.size() == 0) return $urandom;
		return loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
	endfunction

	function automatic logic signed [31:0] load_value(input int unsigned ramp);
		case ($urandom_range(0, 5))
			0, 1: return $signed($urandom_range(0, 16)) - 8;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
				: 32'sh80000000 + $urandom_range(0, 3);
			3, 4: return 32'sh40000000 + ramp;
			default: return $urandom;
		endcase
	endfunction

	// stimulus: directed part, random part, then fill past capacity and query the full store
	initial begin
		logic signed [31:0] a, b;
		int unsigned ramp;
		arst_n = 1'b0;
		start = 1'b0; cmd = 1'b0; position = '0; range_low = '0; range_high = '0;
		err_cnt = 0; idle_cycles = 0; gap_left = 0; took = 1'b0; stim_done = 1'b0;
		store_fill = 0; store_overflow = 1'b0;

		add_query(32'sh80000000, 32'sh7fffffff, 1'b0);
		add_load(32'sh80000000);
		add_load(32'sh7fffffff);
		add_load(0);
		add_load(-1);
		add_load(5); add_load(5); add_load(5);
		add_query(32'sh80000000, 32'sh7fffffff, 1'b0);
		add_query(5, 5, 1'b0);
		add_query(6, 4, 1'b0);
		add_query(32'sh7fffffff, 32'sh7fffffff, 1'b0);
		add_query(32'sh80000000, 32'sh80000000, 1'b0);
		add_query(0, -1, 1'b0);
		add_query(-1, 0, 1'b0);
		add_query(32'sh7fffffff, 32'sh80000000, 1'b0);
		add_query(4, 6, 1'b1);

		ramp = 0;
		for (int i = 0; i < 1310; i++) begin
			if ($urandom_range(0, 99) < 78) begin
				ramp += $urandom_range(0, 3);
				add_load(load_value(ramp));
			end else begin
				case ($urandom_range(0, 3))
					0: begin a = $urandom; b = $urandom; end
					1: begin a = some_loaded(); b = some_loaded(); end
					2: begin
						a = some_loaded() - $urandom_range(0, 2);
						b = a + $urandom_range(0, 4);
					end
					default: begin a = some_loaded(); b = a - $urandom_range(1, 3); end
				endcase
				if ($urandom_range(0, 3) != 0 && a > b) begin
					logic signed [31:0] t;
					t = a; a = b; b = t;
				end
				add_query(a, b, (i % 200) == 199);
			end
		end
		while (loaded_vals.size() < Capacity + 4) begin
			ramp += 1;
			add_load(load_value(ramp));
		end
		add_query(32'sh80000000, 32'sh7fffffff, 1'b0);
		for (int i = 0; i < 8; i++) begin
			a = some_loaded(); b = a + $urandom_range(0, 50);
			add_query(a, b, 1'b0);
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending_words.size() == 0 && !start);
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		stim_done = 1'b1;
		if (err_cnt == 0)
			$display("sorted_range_count_top test passed");
		else
			$display("sorted_range_count_top test failed");
		$finish;
	end

	// driver: one word per start, gaps and an occasional drain hold-off
	always @(negedge clk) begin
		word_t w;
		if (arst_n) begin
			if (!start || took) begin
				if (gap_left > 0 || pending_words.size() == 0 ||
						(pending_words[0].drain && expected_answers.size() != 0)) begin
					start <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					w = pending_words.pop_front();
					start <= 1'b1;
					cmd <= (w.op == CMD_QUERY);
					position <= w.pos;
					range_low <= w.lo;
					range_high <= w.hi;
					gap_left = pick_gap();
				end
			end
		end
	end

	// monitor: predict on acceptance, compare each done word
	always @(posedge clk) begin
		answer_t want;
		took = 1'b0;
		if (arst_n && !stim_done) begin
			if (start && !busy) begin
				took = 1'b1;
				if (cmd) expected_answers.push_back(count_in_range(range_low, range_high));
				else store_insert(position);
			end
			if (done) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("unexpected result, match_count", match_count, -1);
				end else begin
					want = expected_answers.pop_front();
					if (match_count !== want.cnt)
						report_mismatch("match_count", match_count, want.cnt);
					if (dropped_flag !== want.flag)
						report_mismatch("dropped_flag", dropped_flag, want.flag);
				end
			end
			if (took || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: nothing accepted for %0d cycles", IdleLimit);
				$display("sorted_range_count_top test failed");
				$finish;
			end
		end
	end

endmodule

[sim.f]
+incdir+src
src/src_pkg.sv
src/sorted_range_count_top.sv
src/src_checker.sv
tb/tb_top.sv
